FILE: hdl/afpb_pkg.sv
// ----------------------------------------------------------------------------
// afpb_pkg
// Types and constants of the stereo audio frame FIFO with prebuffering.
// ----------------------------------------------------------------------------
package afpb_pkg;

	localparam int unsigned DEFAULT_DEPTH = 1024;
	localparam int unsigned CFG_IDX_W     = 8;
	localparam int unsigned CFG_DATA_W    = 32;

	localparam logic [1:0] REQ_PUSH    = 2'd0;
	localparam logic [1:0] REQ_POP     = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_PREBUFFER = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MUTE      = CFG_IDX_W'(1);

	localparam logic [10:0] PREBUFFER_RESET = 11'd256;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [15:0] left_in;
		logic signed [15:0] right_in;
	} req_beat_t;

	typedef struct packed {
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
		logic               frame_real;
		logic               push_accepted;
		logic [10:0]        fill_level;
		logic               playing;
		logic [31:0]        overflow_count;
		logic [31:0]        underrun_count;
		logic [31:0]        frames_written;
	} rsp_beat_t;

endpackage

FILE: hdl/stereo_audio_fifo_prebuffer_core.sv
// ----------------------------------------------------------------------------
// stereo_audio_fifo_prebuffer_core
// Stereo 16-bit frame FIFO, prebuffer start, mute, saturating error counters.
// ----------------------------------------------------------------------------
// The response beat is registered and follows in the cycle after the request beat.
// Throughput: one beat per cycle unless stalled; the frame store read port
// sits on the pop path; its registered read aligns with the response register.
// Reset: pointers, start flag, counters, mute and valid cleared at once by arst_n;
// response beat register and frame store contents are not cleared.
module stereo_audio_fifo_prebuffer_core #(
	parameter int unsigned DEPTH = afpb_pkg::DEFAULT_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  afpb_pkg::req_beat_t              req_beat,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output afpb_pkg::rsp_beat_t              rsp_beat,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [afpb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [afpb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned PW = $clog2(2 * DEPTH);
	localparam int unsigned FW = $clog2(DEPTH + 1);

	logic [PW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nxt, rd_ptr_nxt;
	logic          started_q, started_nxt;
	logic [31:0]   ovf_q, udr_q, wrt_q, ovf_nxt, udr_nxt, wrt_nxt;
	logic [10:0]   prebuf_q;
	logic          mute_q;

	logic          valid_s1, take_ram_s1;
	afpb_pkg::rsp_beat_t beat_s1, beat_nxt;

	logic          accept, push_ok, pop_ok, take_ram;
	logic [FW-1:0] fill, fill_after;
	logic [31:0]   rdata;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		ptr_next = (p == PW'(2 * DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_index(input logic [PW-1:0] p);
		ptr_index = (p >= PW'(DEPTH)) ? AW'(p - PW'(DEPTH)) : AW'(p);
	endfunction

	assign req_stall = valid_s1 & rsp_stall;
	assign accept    = req_valid & ~req_stall;
	assign rsp_valid = valid_s1;
	assign cfg_ready = 1'b1;

	always_comb begin
		if (wr_ptr_q >= rd_ptr_q) begin
			fill = FW'(wr_ptr_q - rd_ptr_q);
		end else begin
			fill = FW'({1'b0, wr_ptr_q} + (PW + 1)'(2 * DEPTH) - {1'b0, rd_ptr_q});
		end
	end

	always_comb begin
		wr_ptr_nxt  = wr_ptr_q;
		rd_ptr_nxt  = rd_ptr_q;
		started_nxt = started_q;
		ovf_nxt     = ovf_q;
		udr_nxt     = udr_q;
		wrt_nxt     = wrt_q;
		push_ok     = 1'b0;
		pop_ok      = 1'b0;
		fill_after  = fill;
		case (req_beat.req_type)
			afpb_pkg::REQ_PUSH: begin
				if (fill != FW'(DEPTH)) begin
					push_ok    = 1'b1;
					wr_ptr_nxt = ptr_next(wr_ptr_q);
					wrt_nxt    = wrt_q + 32'd1;
					fill_after = fill + FW'(1);
					if (32'(fill_after) >= 32'(prebuf_q)) begin
						started_nxt = 1'b1;
					end
				end else if (ovf_q != '1) begin
					ovf_nxt = ovf_q + 32'd1;
				end
			end
			afpb_pkg::REQ_POP: begin
				if (started_q) begin
					if (fill != '0) begin
						pop_ok     = 1'b1;
						rd_ptr_nxt = ptr_next(rd_ptr_q);
						fill_after = fill - FW'(1);
					end else if (udr_q != '1) begin
						udr_nxt = udr_q + 32'd1;
					end
				end
			end
			afpb_pkg::REQ_RESTART: begin
				wr_ptr_nxt  = '0;
				rd_ptr_nxt  = '0;
				started_nxt = 1'b0;
				ovf_nxt     = '0;
				udr_nxt     = '0;
				wrt_nxt     = '0;
				fill_after  = '0;
			end
			default: begin
			end
		endcase
	end

	assign take_ram = pop_ok & ~mute_q;

	always_comb begin
		beat_nxt                = '0;
		beat_nxt.frame_real     = pop_ok;
		beat_nxt.push_accepted  = push_ok;
		beat_nxt.fill_level     = 11'(fill_after);
		beat_nxt.playing        = started_nxt;
		beat_nxt.overflow_count = ovf_nxt;
		beat_nxt.underrun_count = udr_nxt;
		beat_nxt.frames_written = wrt_nxt;
	end

	afpb_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (accept & push_ok),
		.waddr (ptr_index(wr_ptr_q)),
		.wdata ({req_beat.right_in, req_beat.left_in}),
		.re    (accept & pop_ok),
		.raddr (ptr_index(rd_ptr_q)),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			started_q <= 1'b0;
			ovf_q     <= '0;
			udr_q     <= '0;
			wrt_q     <= '0;
			prebuf_q  <= afpb_pkg::PREBUFFER_RESET;
			mute_q    <= 1'b0;
			valid_s1  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == afpb_pkg::CFG_PREBUFFER) begin
					prebuf_q <= cfg_wdata[10:0];
				end else if (cfg_index == afpb_pkg::CFG_MUTE) begin
					mute_q <= cfg_wdata[0];
				end
			end
			if (accept) begin
				wr_ptr_q  <= wr_ptr_nxt;
				rd_ptr_q  <= rd_ptr_nxt;
				started_q <= started_nxt;
				ovf_q     <= ovf_nxt;
				udr_q     <= udr_nxt;
				wrt_q     <= wrt_nxt;
			end
			valid_s1 <= accept | (valid_s1 & rsp_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			beat_s1     <= beat_nxt;
			take_ram_s1 <= take_ram;
		end
	end

	always_comb begin
		rsp_beat = beat_s1;
		if (take_ram_s1) begin
			rsp_beat.left_out  = rdata[15:0];
			rsp_beat.right_out = rdata[31:16];
		end
	end

endmodule

FILE: hdl/afpb_ram.sv
// ----------------------------------------------------------------------------
// afpb_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module afpb_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/afpb_checker.sv
// ----------------------------------------------------------------------------
// afpb_checker
// Port-level checks on the audio frame FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module afpb_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_stall,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input afpb_pkg::rsp_beat_t rsp_beat
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response beat dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(rsp_beat))
		else $error("response beat changed while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> req_stall)
		else $error("request taken while response held");

	a_silence: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_beat.frame_real |->
			rsp_beat.left_out == 16'sd0 && rsp_beat.right_out == 16'sd0)
		else $error("samples on a beat without a stored frame");

	a_push_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_beat.push_accepted |->
			!rsp_beat.frame_real && rsp_beat.fill_level != 11'd0)
		else $error("stored push with empty fill level");

endmodule

bind stereo_audio_fifo_prebuffer_core afpb_checker u_afpb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_beat  (rsp_beat)
);
